>>> src/aprr_pkg.sv
// ----------------------------------------------------------------------------
// aprr_pkg
// Shared types, constants and helpers of the audio packet ring receiver.
// ----------------------------------------------------------------------------
package aprr_pkg;

  localparam int RING_BYTES   = 4096;
  localparam int PTR_W        = $clog2(RING_BYTES);
  localparam int FILL_W       = PTR_W + 1;
  localparam int MAX_PAYLOAD  = 1436;
  localparam int MAX_FRAMES   = 64;
  localparam int RATE_LIMIT   = 21;
  localparam int BUDGET_W     = 11;

  // fixed field widths
  localparam int REQ_TYPE_W   = 2;
  localparam int RATE_W       = 5;
  localparam int CHAN_W       = 9;
  localparam int SAMPLE_W     = 9;
  localparam int PAYLOAD_W    = 11;
  localparam int BYTE_W       = 8;
  localparam int FRAME_REQ_W  = 7;
  localparam int HALF_W       = 16;
  localparam int LCH_W        = 2;

  typedef logic [REQ_TYPE_W-1:0] req_type_t;
  localparam req_type_t REQ_HEADER = 2'd0;
  localparam req_type_t REQ_BYTE   = 2'd1;
  localparam req_type_t REQ_READ   = 2'd2;

  typedef logic [1:0] status_t;
  localparam status_t ST_ACCEPTED  = 2'd0;
  localparam status_t ST_BAD_HDR   = 2'd1;
  localparam status_t ST_UNSUP     = 2'd2;
  localparam status_t ST_MISMATCH  = 2'd3;

  localparam logic KIND_HEADER = 1'b0;
  localparam logic KIND_READ   = 1'b1;

  // header verdict passed from the checker to the control
  typedef struct packed {
    status_t               status;
    logic                  lock_now;
    logic [BUDGET_W-1:0]   budget;
  } hdr_res_t;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    r = (p == PTR_W'(RING_BYTES - 1)) ? '0 : p + PTR_W'(1);
    return r;
  endfunction

endpackage

>>> src/aprr_in_if.sv
// ----------------------------------------------------------------------------
// aprr_in_if
// Input channel: header, payload byte and read request items.
// ----------------------------------------------------------------------------
interface aprr_in_if;
  logic                             valid;
  logic                             ready;
  logic [aprr_pkg::REQ_TYPE_W-1:0]  req_type;
  logic                             header_ok;
  logic                             is_pcm16;
  logic [aprr_pkg::RATE_W-1:0]      rate_index;
  logic [aprr_pkg::CHAN_W-1:0]      channel_count;
  logic [aprr_pkg::SAMPLE_W-1:0]    sample_count;
  logic [aprr_pkg::PAYLOAD_W-1:0]   payload_length;
  logic [aprr_pkg::BYTE_W-1:0]      data_byte;
  logic [aprr_pkg::FRAME_REQ_W-1:0] frame_request;

  modport source (
    output valid, req_type, header_ok, is_pcm16, rate_index, channel_count,
           sample_count, payload_length, data_byte, frame_request,
    input  ready
  );
  modport sink (
    input  valid, req_type, header_ok, is_pcm16, rate_index, channel_count,
           sample_count, payload_length, data_byte, frame_request,
    output ready
  );
endinterface

// ----------------------------------------------------------------------------
// aprr_out_if
// Result channel: header status and read frame items.
// ----------------------------------------------------------------------------
interface aprr_out_if;
  logic                        valid;
  logic                        ready;
  logic                        result_kind;
  logic [1:0]                  status;
  logic                        frame_valid;
  logic [aprr_pkg::HALF_W-1:0] left_bytes;
  logic [aprr_pkg::HALF_W-1:0] right_bytes;
  logic                        last_in_run;

  modport source (
    output valid, result_kind, status, frame_valid, left_bytes, right_bytes,
           last_in_run,
    input  ready
  );
  modport sink (
    input  valid, result_kind, status, frame_valid, left_bytes, right_bytes,
           last_in_run,
    output ready
  );
endinterface

>>> src/audio_packet_ring_receiver_core.sv
// ----------------------------------------------------------------------------
// audio_packet_ring_receiver_core
// PCM16 packet admission with a drop-oldest byte ring and frame reads.
// ----------------------------------------------------------------------------
// Payload streams in at one byte per cycle while the result port is not
// stalled; a header returns one status item. A read request starts a run in
// which each frame is fetched byte by byte (2 bytes for mono, 4 for stereo),
// handed to the output register and, but for the last frame of the run,
// followed by a wait until that register is free. The ring sits in one memory
// whose single read port yields one byte per cycle; no new input item is
// taken until the run is delivered. The ring needs no clearing pass: only
// bytes already written are ever read, so the block is ready right after
// reset. When the ring is full a push drops its oldest byte.
module audio_packet_ring_receiver_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic              cfg_wdata,
  aprr_in_if.sink           in_ch,
  aprr_out_if.source        out_ch
);
  import aprr_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_FETCH = 4'b0010,
    S_DRAIN = 4'b0100,
    S_WAIT  = 4'b1000
  } state_t;

  state_t                 state_r, state_nxt;
  logic                   enable_r, enable_nxt;
  logic [PTR_W-1:0]       rptr_r, rptr_nxt;
  logic [PTR_W-1:0]       wptr_r, wptr_nxt;
  logic [FILL_W-1:0]      fill_r, fill_nxt;
  logic                   locked_r, locked_nxt;
  logic [RATE_W-1:0]      lrate_r, lrate_nxt;
  logic [LCH_W-1:0]       lch_r, lch_nxt;
  logic [BUDGET_W-1:0]    budget_r, budget_nxt;
  logic [FRAME_REQ_W-1:0] frames_r, frames_nxt;
  logic [1:0]             bcnt_r, bcnt_nxt;
  logic                   pend_r, pend_nxt;
  logic [4*BYTE_W-1:0]    frame_r, frame_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic                   o_kind_r, o_kind_nxt;
  status_t                o_status_r, o_status_nxt;
  logic                   o_fv_r, o_fv_nxt;
  logic [HALF_W-1:0]      o_left_r, o_left_nxt;
  logic [HALF_W-1:0]      o_right_r, o_right_nxt;
  logic                   o_last_r, o_last_nxt;

  hdr_res_t               hres;
  logic                   in_acc;
  logic                   out_free;
  logic                   stereo_lk;
  logic                   ram_we;
  logic [BYTE_W-1:0]      ram_rdata;
  logic [FILL_W-2:0]      avail;
  logic [FRAME_REQ_W-1:0] req_sat;
  logic [FRAME_REQ_W-1:0] take;
  logic [4*BYTE_W-1:0]    assembled;

  aprr_hdr u_hdr (
    .header_ok       (in_ch.header_ok),
    .is_pcm16        (in_ch.is_pcm16),
    .rate_index      (in_ch.rate_index),
    .channel_count   (in_ch.channel_count),
    .sample_count    (in_ch.sample_count),
    .payload_length  (in_ch.payload_length),
    .locked          (locked_r),
    .locked_rate     (lrate_r),
    .locked_channels (lch_r),
    .res             (hres)
  );

  aprr_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (RING_BYTES)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wptr_r),
    .wdata (in_ch.data_byte),
    .raddr (rptr_r),
    .rdata (ram_rdata)
  );

  assign out_free     = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = (state_r == S_IDLE) && out_free;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign stereo_lk    = (lch_r == LCH_W'(2));
  assign ram_we       = in_acc && enable_r && (in_ch.req_type == REQ_BYTE) &&
                        (budget_r != '0);

  always_comb begin
    if (!locked_r) begin
      avail = '0;
    end else if (stereo_lk) begin
      avail = (FILL_W-1)'(fill_r >> 2);
    end else begin
      avail = (FILL_W-1)'(fill_r >> 1);
    end
    req_sat = (in_ch.frame_request > FRAME_REQ_W'(MAX_FRAMES))
              ? FRAME_REQ_W'(MAX_FRAMES) : in_ch.frame_request;
    take    = ((FILL_W-1)'(req_sat) < avail) ? req_sat : avail[FRAME_REQ_W-1:0];
    assembled = {ram_rdata, frame_r[4*BYTE_W-1:BYTE_W]};
  end

  always_comb begin
    state_nxt     = state_r;
    enable_nxt    = cfg_we ? cfg_wdata : enable_r;
    rptr_nxt      = rptr_r;
    wptr_nxt      = wptr_r;
    fill_nxt      = fill_r;
    locked_nxt    = locked_r;
    lrate_nxt     = lrate_r;
    lch_nxt       = lch_r;
    budget_nxt    = budget_r;
    frames_nxt    = frames_r;
    bcnt_nxt      = bcnt_r;
    pend_nxt      = 1'b0;
    frame_nxt     = pend_r ? assembled : frame_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    o_kind_nxt    = o_kind_r;
    o_status_nxt  = o_status_r;
    o_fv_nxt      = o_fv_r;
    o_left_nxt    = o_left_r;
    o_right_nxt   = o_right_r;
    o_last_nxt    = o_last_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc && enable_r) begin
          unique case (in_ch.req_type)
            REQ_HEADER: begin
              budget_nxt = hres.budget;
              if (hres.lock_now) begin
                locked_nxt = 1'b1;
                lrate_nxt  = in_ch.rate_index;
                lch_nxt    = in_ch.channel_count[LCH_W-1:0];
              end
              out_valid_nxt = 1'b1;
              o_kind_nxt    = KIND_HEADER;
              o_status_nxt  = hres.status;
              o_fv_nxt      = 1'b0;
              o_left_nxt    = '0;
              o_right_nxt   = '0;
              o_last_nxt    = 1'b1;
            end
            REQ_BYTE: begin
              if (budget_r != '0) begin
                budget_nxt = budget_r - BUDGET_W'(1);
                wptr_nxt   = ptr_inc(wptr_r);
                // full ring: oldest byte goes, fill stays
                if (fill_r == FILL_W'(RING_BYTES)) begin
                  rptr_nxt = ptr_inc(rptr_r);
                end else begin
                  fill_nxt = fill_r + FILL_W'(1);
                end
              end
            end
            REQ_READ: begin
              if (take == '0) begin
                out_valid_nxt = 1'b1;
                o_kind_nxt    = KIND_READ;
                o_status_nxt  = ST_ACCEPTED;
                o_fv_nxt      = 1'b0;
                o_left_nxt    = '0;
                o_right_nxt   = '0;
                o_last_nxt    = 1'b1;
              end else begin
                frames_nxt = take;
                bcnt_nxt   = '0;
                state_nxt  = S_FETCH;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_FETCH: begin
        rptr_nxt = ptr_inc(rptr_r);
        fill_nxt = fill_r - FILL_W'(1);
        pend_nxt = 1'b1;
        bcnt_nxt = bcnt_r + 2'd1;
        if (bcnt_r == (stereo_lk ? 2'd3 : 2'd1)) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        out_valid_nxt = 1'b1;
        o_kind_nxt    = KIND_READ;
        o_status_nxt  = ST_ACCEPTED;
        o_fv_nxt      = 1'b1;
        o_left_nxt    = stereo_lk ? assembled[HALF_W-1:0] : assembled[2*HALF_W-1:HALF_W];
        o_right_nxt   = stereo_lk ? assembled[2*HALF_W-1:HALF_W] : '0;
        o_last_nxt    = (frames_r == FRAME_REQ_W'(1));
        frames_nxt    = frames_r - FRAME_REQ_W'(1);
        state_nxt     = (frames_r == FRAME_REQ_W'(1)) ? S_IDLE : S_WAIT;
      end
      S_WAIT: begin
        // next frame starts once the output register can take it
        if (out_free) begin
          bcnt_nxt  = '0;
          state_nxt = S_FETCH;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      enable_r    <= 1'b1;
      rptr_r      <= '0;
      wptr_r      <= '0;
      fill_r      <= '0;
      locked_r    <= 1'b0;
      lrate_r     <= '0;
      lch_r       <= '0;
      budget_r    <= '0;
      frames_r    <= '0;
      bcnt_r      <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      enable_r    <= enable_nxt;
      rptr_r      <= rptr_nxt;
      wptr_r      <= wptr_nxt;
      fill_r      <= fill_nxt;
      locked_r    <= locked_nxt;
      lrate_r     <= lrate_nxt;
      lch_r       <= lch_nxt;
      budget_r    <= budget_nxt;
      frames_r    <= frames_nxt;
      bcnt_r      <= bcnt_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    frame_r    <= frame_nxt;
    o_kind_r   <= o_kind_nxt;
    o_status_r <= o_status_nxt;
    o_fv_r     <= o_fv_nxt;
    o_left_r   <= o_left_nxt;
    o_right_r  <= o_right_nxt;
    o_last_r   <= o_last_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.result_kind = o_kind_r;
  assign out_ch.status      = o_status_r;
  assign out_ch.frame_valid = o_fv_r;
  assign out_ch.left_bytes  = o_left_r;
  assign out_ch.right_bytes = o_right_r;
  assign out_ch.last_in_run = o_last_r;

endmodule

>>> src/aprr_ram.sv
// ----------------------------------------------------------------------------
// aprr_ram
// Generic single-clock RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module aprr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/aprr_hdr.sv
// ----------------------------------------------------------------------------
// aprr_hdr
// Header check against the locked format and push budget computation.
// ----------------------------------------------------------------------------
module aprr_hdr (
  input  logic                             header_ok,
  input  logic                             is_pcm16,
  input  logic [aprr_pkg::RATE_W-1:0]      rate_index,
  input  logic [aprr_pkg::CHAN_W-1:0]      channel_count,
  input  logic [aprr_pkg::SAMPLE_W-1:0]    sample_count,
  input  logic [aprr_pkg::PAYLOAD_W-1:0]   payload_length,
  input  logic                             locked,
  input  logic [aprr_pkg::RATE_W-1:0]      locked_rate,
  input  logic [aprr_pkg::LCH_W-1:0]       locked_channels,
  output aprr_pkg::hdr_res_t               res
);
  import aprr_pkg::*;

  logic                 ch_ok;
  logic                 stereo;
  logic [BUDGET_W-1:0]  pay_sat;
  logic [BUDGET_W-1:0]  want;
  logic [BUDGET_W-1:0]  use_bytes;
  status_t              st;

  always_comb begin
    ch_ok  = (channel_count == CHAN_W'(1)) || (channel_count == CHAN_W'(2));
    stereo = (channel_count == CHAN_W'(2));
    priority if (!header_ok) begin
      st = ST_BAD_HDR;
    end else if (!is_pcm16 || (rate_index >= RATE_W'(RATE_LIMIT)) || !ch_ok) begin
      st = ST_UNSUP;
    end else if (locked && ((locked_rate != rate_index) ||
                            ({{(CHAN_W-LCH_W){1'b0}}, locked_channels} != channel_count))) begin
      st = ST_MISMATCH;
    end else begin
      st = ST_ACCEPTED;
    end

    pay_sat = (payload_length > PAYLOAD_W'(MAX_PAYLOAD))
              ? BUDGET_W'(MAX_PAYLOAD) : BUDGET_W'(payload_length);
    want    = stereo ? BUDGET_W'({sample_count, 2'b00})
                     : BUDGET_W'({sample_count, 1'b0});
    use_bytes = (pay_sat < want) ? pay_sat : want;

    res.status   = st;
    res.lock_now = (st == ST_ACCEPTED) && !locked;
    // trim to whole frames
    if (st != ST_ACCEPTED) begin
      res.budget = '0;
    end else if (stereo) begin
      res.budget = {use_bytes[BUDGET_W-1:2], 2'b00};
    end else begin
      res.budget = {use_bytes[BUDGET_W-1:1], 1'b0};
    end
  end

endmodule

>>> src/aprr_chk.sv
// ----------------------------------------------------------------------------
// aprr_chk
// Port-level checks on the result channel of the ring receiver.
// ----------------------------------------------------------------------------
module aprr_chk (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        result_kind,
  input logic [1:0]                  status,
  input logic                        frame_valid,
  input logic [aprr_pkg::HALF_W-1:0] left_bytes,
  input logic [aprr_pkg::HALF_W-1:0] right_bytes,
  input logic                        last_in_run
);
  import aprr_pkg::*;

  // nothing offered straight after reset
  a_reset_quiet: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result offered right after reset");

  a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn while stalled");

  a_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable({result_kind, status, frame_valid,
                                         left_bytes, right_bytes, last_in_run}))
    else $error("stalled result changed");

  // header status item carries no frame and closes its run
  a_header_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (result_kind == KIND_HEADER) |->
      last_in_run && !frame_valid && (left_bytes == '0) && (right_bytes == '0))
    else $error("malformed header status item");

  // empty read answer is a single closing item
  a_empty_read: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (result_kind == KIND_READ) && !frame_valid |->
      last_in_run && (status == ST_ACCEPTED) && (left_bytes == '0) &&
      (right_bytes == '0))
    else $error("malformed empty read item");

endmodule

bind audio_packet_ring_receiver_core aprr_chk u_aprr_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .result_kind (out_ch.result_kind),
  .status      (out_ch.status),
  .frame_valid (out_ch.frame_valid),
  .left_bytes  (out_ch.left_bytes),
  .right_bytes (out_ch.right_bytes),
  .last_in_run (out_ch.last_in_run)
);

>>> tb/sv/audio_packet_ring_receiver_core_tb.sv
// ----------------------------------------------------------------------------
// audio_packet_ring_receiver_core_tb
// Self-checking bench for the packet ring receiver. Headers, payload bytes
// and read requests are sent in random bursts, and results are taken under a
// shifting stall pattern. A local copy of the ring and of the locked format
// works out every header status and popped frame. The run covers the enable
// register, rejected and mismatched headers, budget trimming and ring overflow.
// ----------------------------------------------------------------------------
module audio_packet_ring_receiver_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import aprr_pkg::*;

  localparam req_type_t REQ_UNUSED    = 2'd3;
  localparam int        SAMPLE_BYTES  = 16 / 8;
  localparam int        SETTLE_CYCLES = 16;

  typedef struct {
    req_type_t              kind;
    logic                   hdr_ok;
    logic                   pcm16;
    logic [RATE_W-1:0]      rate;
    logic [CHAN_W-1:0]      chans;
    logic [SAMPLE_W-1:0]    samples;
    logic [PAYLOAD_W-1:0]   paylen;
    logic [BYTE_W-1:0]      data;
    logic [FRAME_REQ_W-1:0] frames;
  } pkt_item_t;

  typedef struct {
    logic              kind;
    status_t           status;
    logic              fvalid;
    logic [HALF_W-1:0] left_h;
    logic [HALF_W-1:0] right_h;
    logic              last;
  } reply_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_wdata;

  aprr_in_if  in_bus ();
  aprr_out_if out_bus ();

  audio_packet_ring_receiver_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_bus),
    .out_ch    (out_bus)
  );

  // local copy of the receiver state
  logic [BYTE_W-1:0] ring_mem [RING_BYTES];
  int   rd_ptr      = 0;
  int   wr_ptr      = 0;
  int   fill        = 0;
  bit   fmt_locked  = 1'b0;
  int   lk_rate     = 0;
  int   lk_chans    = 0;
  int   budget_left = 0;
  bit   rx_enable   = 1'b1;

  reply_t    status_and_frames_q [$];
  pkt_item_t send_q [$];
  int        queued_n  = 0;
  int        taken_n   = 0;
  int        err_count = 0;
  logic      item_taken = 1'b0;
  int        burst_left = 1;
  int        gap_left   = 0;
  int        stall_mode = 0;
  int        mode_left  = 0;
  logic [7:0] stall_mask = 8'hff;

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  function automatic logic [BYTE_W-1:0] ring_pop();
    logic [BYTE_W-1:0] b;
    b = ring_mem[rd_ptr];
    rd_ptr = (rd_ptr + 1) % RING_BYTES;
    fill--;
    return b;
  endfunction

  task automatic ring_receiver_step(input pkt_item_t it);
    reply_t r;
    int bpf, pay, want_n, use_n, req, take;
    logic [BYTE_W-1:0] b0, b1, b2, b3;
    if (!rx_enable) return;
    bpf = lk_chans * SAMPLE_BYTES;
    r = '{KIND_HEADER, ST_ACCEPTED, 1'b0, '0, '0, 1'b1};
    case (it.kind)
      REQ_HEADER: begin
        if (!it.hdr_ok) begin
          r.status = ST_BAD_HDR;
        end else if (!it.pcm16 || it.rate >= RATE_LIMIT || it.chans < 1 || it.chans > 2) begin
          r.status = ST_UNSUP;
        end else if (!fmt_locked) begin
          fmt_locked = 1'b1;
          lk_rate    = it.rate;
          lk_chans   = it.chans;
        end else if (lk_rate != it.rate || lk_chans != it.chans) begin
          r.status = ST_MISMATCH;
        end
        if (r.status == ST_ACCEPTED) begin
          bpf    = lk_chans * SAMPLE_BYTES;
          pay    = (it.paylen > MAX_PAYLOAD) ? MAX_PAYLOAD : it.paylen;
          want_n = it.samples * bpf;
          use_n  = (pay < want_n) ? pay : want_n;
          budget_left = use_n - use_n % bpf;
        end else begin
          budget_left = 0;
        end
        status_and_frames_q.push_back(r);
      end
      REQ_BYTE: begin
        if (budget_left > 0) begin
          // full ring loses its oldest byte
          if (fill >= RING_BYTES) begin
            rd_ptr = (rd_ptr + 1) % RING_BYTES;
            fill   = RING_BYTES - 1;
          end
          ring_mem[wr_ptr] = it.data;
          wr_ptr = (wr_ptr + 1) % RING_BYTES;
          fill++;
          budget_left--;
        end
      end
      REQ_READ: begin
        req  = (it.frames > MAX_FRAMES) ? MAX_FRAMES : it.frames;
        take = (fmt_locked && bpf != 0) ? fill / bpf : 0;
        if (req < take) take = req;
        r.kind = KIND_READ;
        if (take == 0) status_and_frames_q.push_back(r);
        for (int i = 0; i < take; i++) begin
          b0 = ring_pop();
          b1 = ring_pop();
          r.fvalid  = 1'b1;
          r.left_h  = {b1, b0};
          r.right_h = '0;
          if (lk_chans == 2) begin
            b2 = ring_pop();
            b3 = ring_pop();
            r.right_h = {b3, b2};
          end
          r.last = (i == take - 1);
          status_and_frames_q.push_back(r);
        end
      end
      default: ;
    endcase
  endtask

  function automatic void check_field(input string name, input logic [31:0] exp_v,
                                      input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, actual %0h", name, exp_v, act_v);
      err_count++;
    end
  endfunction

  // input acceptance, register writes and result checks, all at the rising edge
  always @(posedge clk) begin : watch
    pkt_item_t got;
    reply_t    want;
    item_taken <= rst_n && in_bus.valid && in_bus.ready;
    if (rst_n) begin
      if (cfg_we) rx_enable = cfg_wdata;
      if (in_bus.valid && in_bus.ready) begin
        got.kind    = in_bus.req_type;
        got.hdr_ok  = in_bus.header_ok;
        got.pcm16   = in_bus.is_pcm16;
        got.rate    = in_bus.rate_index;
        got.chans   = in_bus.channel_count;
        got.samples = in_bus.sample_count;
        got.paylen  = in_bus.payload_length;
        got.data    = in_bus.data_byte;
        got.frames  = in_bus.frame_request;
        taken_n++;
        ring_receiver_step(got);
      end
      if (out_bus.valid === 1'b1 && out_bus.ready) begin
        if (status_and_frames_q.size() == 0) begin
          $error("result with nothing pending: result_kind %0d", out_bus.result_kind);
          err_count++;
        end else begin
          want = status_and_frames_q.pop_front();
          check_field("result_kind", want.kind, out_bus.result_kind);
          check_field("status", want.status, out_bus.status);
          check_field("frame_valid", want.fvalid, out_bus.frame_valid);
          check_field("left_bytes", want.left_h, out_bus.left_bytes);
          check_field("right_bytes", want.right_h, out_bus.right_bytes);
          check_field("last_in_run", want.last, out_bus.last_in_run);
        end
      end
    end
  end

  // sender: bursts of items with random gaps between them
  always @(negedge clk) begin : drive_items
    pkt_item_t nxt;
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else if (!in_bus.valid || item_taken) begin
      if (gap_left > 0) begin
        gap_left     <= gap_left - 1;
        in_bus.valid <= 1'b0;
      end else if (send_q.size() == 0) begin
        in_bus.valid <= 1'b0;
      end else begin
        nxt = send_q.pop_front();
        in_bus.valid          <= 1'b1;
        in_bus.req_type       <= nxt.kind;
        in_bus.header_ok      <= nxt.hdr_ok;
        in_bus.is_pcm16       <= nxt.pcm16;
        in_bus.rate_index     <= nxt.rate;
        in_bus.channel_count  <= nxt.chans;
        in_bus.sample_count   <= nxt.samples;
        in_bus.payload_length <= nxt.paylen;
        in_bus.data_byte      <= nxt.data;
        in_bus.frame_request  <= nxt.frames;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 48);
          case ($urandom_range(0, 3))
            0:       gap_left <= 0;
            1, 2:    gap_left <= $urandom_range(1, 4);
            default: gap_left <= $urandom_range(5, 20);
          endcase
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // receiver: free flow, random, rotating mask or a long stall
  always @(negedge clk) begin
    if (mode_left == 0) begin
      stall_mode    <= $urandom_range(0, 3);
      mode_left     <= $urandom_range(20, 120);
      stall_mask    <= $urandom | 8'h01;
      out_bus.ready <= 1'b1;
    end else begin
      mode_left <= mode_left - 1;
      case (stall_mode)
        0: out_bus.ready <= 1'b1;
        1: out_bus.ready <= ($urandom_range(0, 3) != 0);
        2: begin
          out_bus.ready <= stall_mask[0];
          stall_mask    <= {stall_mask[0], stall_mask[7:1]};
        end
        default: out_bus.ready <= (mode_left < 4);
      endcase
    end
  end

  function automatic pkt_item_t any_item();
    pkt_item_t it;
    it.kind    = req_type_t'($urandom_range(0, 2));
    it.hdr_ok  = $urandom;
    it.pcm16   = $urandom;
    it.rate    = $urandom;
    it.chans   = $urandom_range(1, 256);
    it.samples = $urandom_range(1, 256);
    it.paylen  = $urandom;
    it.data    = $urandom;
    it.frames  = $urandom;
    return it;
  endfunction

  function automatic pkt_item_t mk_header(input bit ok, input bit pcm, input int rate,
                                          input int chans, input int samples, input int plen);
    pkt_item_t it;
    it = any_item();
    it.kind    = REQ_HEADER;
    it.hdr_ok  = ok;
    it.pcm16   = pcm;
    it.rate    = rate;
    it.chans   = chans;
    it.samples = samples;
    it.paylen  = plen;
    return it;
  endfunction

  function automatic pkt_item_t mk_byte(input logic [BYTE_W-1:0] b);
    pkt_item_t it;
    it = any_item();
    it.kind = REQ_BYTE;
    it.data = b;
    return it;
  endfunction

  function automatic pkt_item_t mk_read(input int n);
    pkt_item_t it;
    it = any_item();
    it.kind   = REQ_READ;
    it.frames = n;
    return it;
  endfunction

  task automatic send(input pkt_item_t it);
    send_q.push_back(it);
    queued_n++;
  endtask

  // sender holds off here until every item is in and every result is out
  task automatic wait_drained();
    do @(negedge clk); while (taken_n != queued_n || status_and_frames_q.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_enable(input logic v);
    @(negedge clk);
    cfg_wdata <= v;
    cfg_we    <= 1'b1;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic random_traffic(input int target, input int lc, input int lr);
    int counted, pick, plen, nb;
    pkt_item_t it;
    counted = 0;
    while (counted < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        // well-formed packet, now and then with a few bytes too many
        case ($urandom_range(0, 19))
          0:          plen = $urandom_range(MAX_PAYLOAD + 1, 2047);
          1, 2, 3, 4: plen = $urandom_range(25, MAX_PAYLOAD);
          default:    plen = $urandom_range(0, 24);
        endcase
        send(mk_header(1'b1, 1'b1, lr, lc,
                       $urandom_range(0, 1) ? $urandom_range(1, 8) : $urandom_range(1, 256),
                       plen));
        nb = (plen > 48) ? $urandom_range(0, 48) : plen;
        if ($urandom_range(0, 7) == 0) nb += $urandom_range(1, 3);
        repeat (nb) send(mk_byte($urandom));
        counted += 1 + nb;
      end else if (pick < 80) begin
        case ($urandom_range(0, 9))
          0:       send(mk_read(0));
          1:       send(mk_read($urandom_range(MAX_FRAMES, 127)));
          2:       send(mk_read($urandom_range(9, MAX_FRAMES - 1)));
          default: send(mk_read($urandom_range(1, 8)));
        endcase
        counted++;
      end else if (pick < 92) begin
        it = any_item();
        it.kind = REQ_HEADER;
        if ($urandom_range(0, 1)) begin
          it.hdr_ok = 1'b1;
          it.pcm16  = 1'b1;
          it.rate   = $urandom_range(0, RATE_LIMIT - 1);
          it.chans  = $urandom_range(1, 2);
        end
        send(it);
        repeat ($urandom_range(0, 3)) send(mk_byte($urandom));
        counted++;
      end else if (pick < 97) begin
        repeat ($urandom_range(1, 4)) send(mk_byte($urandom));
      end else begin
        it = any_item();
        it.kind = REQ_UNUSED;
        send(it);
      end
    end
  endtask

  initial begin : stimulus
    int lc, lr, alt_rate, bpf;
    pkt_item_t it;
    rst_n                 = 1'b0;
    cfg_we                = 1'b0;
    cfg_wdata             = 1'b1;
    in_bus.valid          = 1'b0;
    in_bus.req_type       = REQ_HEADER;
    in_bus.header_ok      = 1'b0;
    in_bus.is_pcm16       = 1'b0;
    in_bus.rate_index     = '0;
    in_bus.channel_count  = '0;
    in_bus.sample_count   = '0;
    in_bus.payload_length = '0;
    in_bus.data_byte      = '0;
    in_bus.frame_request  = '0;
    out_bus.ready         = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // the first good header fixes the format for the whole run
    lc = $urandom_range(1, 2);
    case ($urandom_range(0, 2))
      0:       lr = 0;
      1:       lr = RATE_LIMIT - 1;
      default: lr = $urandom_range(0, RATE_LIMIT - 1);
    endcase
    alt_rate = (lr + 1) % RATE_LIMIT;
    bpf      = lc * SAMPLE_BYTES;

    write_enable(1'b1);

    // directed: rejections, lock, mismatch, budget trim, read corners
    send(mk_read(5));
    send(mk_header(1'b0, 1'b1, lr, lc, 8, 8));
    send(mk_header(1'b1, 1'b0, lr, lc, 8, 8));
    send(mk_header(1'b1, 1'b1, RATE_LIMIT, lc, 8, 8));
    send(mk_header(1'b1, 1'b1, 31, lc, 8, 8));
    send(mk_header(1'b1, 1'b1, lr, 256, 8, 8));
    send(mk_header(1'b1, 1'b1, lr, 3, 8, 8));
    send(mk_byte(8'h5a));
    send(mk_header(1'b1, 1'b1, lr, lc, 256, 7));
    send(mk_byte(8'h00));
    send(mk_byte(8'hff));
    send(mk_byte(8'h81));
    send(mk_byte(8'h7e));
    send(mk_byte(8'ha5));
    send(mk_byte(8'h3c));
    send(mk_byte(8'hc3));
    send(mk_header(1'b1, 1'b1, alt_rate, lc, 8, 8));
    send(mk_byte(8'h11));
    send(mk_header(1'b1, 1'b1, lr, 3 - lc, 8, 8));
    send(mk_header(1'b1, 1'b1, lr, lc, 256, 2047));
    repeat (6) send(mk_byte($urandom));
    it = any_item();
    it.kind = REQ_UNUSED;
    send(it);
    send(mk_read(0));
    send(mk_read(1));
    send(mk_read(127));
    send(mk_read(MAX_FRAMES));
    wait_drained();

    // disabled: nothing below may leave a trace
    write_enable(1'b0);
    send(mk_header(1'b1, 1'b1, lr, lc, 256, 40));
    repeat (4) send(mk_byte($urandom));
    send(mk_read(MAX_FRAMES));
    send(mk_header(1'b1, 1'b1, alt_rate, lc, 8, 8));
    wait_drained();
    write_enable(1'b1);

    random_traffic(200, lc, lr);
    wait_drained();

    // overflow: more than a ring of bytes, then read it all back
    repeat (RING_BYTES / (256 * bpf) + 1) begin
      send(mk_header(1'b1, 1'b1, lr, lc, 256, MAX_PAYLOAD));
      repeat (256 * bpf) send(mk_byte($urandom));
    end
    repeat (RING_BYTES / bpf / MAX_FRAMES + 1) send(mk_read(MAX_FRAMES));
    wait_drained();

    write_enable(1'b0);
    send(mk_read(3));
    send(mk_byte($urandom));
    wait_drained();
    write_enable(1'b1);

    random_traffic(200, lc, lr);
    wait_drained();

    if (err_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

>>> filelist.f
src/aprr_pkg.sv
src/aprr_in_if.sv
src/aprr_ram.sv
src/aprr_hdr.sv
src/audio_packet_ring_receiver_core.sv
src/aprr_chk.sv
tb/sv/audio_packet_ring_receiver_core_tb.sv
